### sv/bsr_pkg.sv
// Package for the byte stream reassembler: window sizing constants, the
// queue entry passed from front to back, and the window status fed back.
// No dependencies.
package bsr_pkg;

   localparam int WINDOW_BYTES = 64;
   localparam int SLOT_W       = (WINDOW_BYTES > 1) ? $clog2(WINDOW_BYTES) : 1;
   localparam int CNT_W        = 7;
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam logic [SLOT_W-1:0] SLOT_ONE  = SLOT_W'(1);
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_BYTES - 1);
   localparam logic [SLOT_W:0]   WIN_EXT   = (SLOT_W + 1)'(WINDOW_BYTES);
   localparam logic [31:0]       WIN_32    = 32'(WINDOW_BYTES);
   localparam logic [CNT_W-1:0]  PEND_MAX  = CNT_W'(WINDOW_BYTES);
   localparam logic [QPTR_W-1:0] QPTR_LAST = QPTR_W'(QUEUE_DEPTH - 1);
   localparam logic [QCNT_W-1:0] QCNT_FULL = QCNT_W'(QUEUE_DEPTH);

   // One classified item, front to back
   typedef struct packed {
      logic              store;
      logic [SLOT_W-1:0] slot;
      logic [7:0]        data;
      logic              seg_end;
      logic              eof_take;
      logic [32:0]       eof_pos;
   } entry_type;

   // Window position, back to front
   typedef struct packed {
      logic [31:0]       next_expected;
      logic [SLOT_W-1:0] base_slot;
   } win_type;

   // Result channel, back to top level
   typedef struct packed {
      logic             strobe;
      logic             has_byte;
      logic [7:0]       out_byte;
      logic [CNT_W-1:0] pending_count;
      logic             stream_ended;
      logic             last;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_DRAIN = 2'b10
   } back_state_type;

endpackage

### sv/bsr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bsr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/bsr_queue.sv
// Short FIFO of classified items between the front and the back.
// Depends on bsr_pkg.
module bsr_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  bsr_pkg::entry_type  push_entry,
   input  logic                pop,
   output bsr_pkg::entry_type  head,
   output logic                not_empty,
   output logic                full
);

   bsr_pkg::entry_type                 slots_ff [bsr_pkg::QUEUE_DEPTH];
   logic [bsr_pkg::QPTR_W-1:0]         wptr_ff, wptr_in;
   logic [bsr_pkg::QPTR_W-1:0]         rptr_ff, rptr_in;
   logic [bsr_pkg::QCNT_W-1:0]         count_ff, count_in;

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (push) begin
         wptr_in = (wptr_ff == bsr_pkg::QPTR_LAST) ? '0 : wptr_ff + 1'b1;
      end
      if (pop) begin
         rptr_in = (rptr_ff == bsr_pkg::QPTR_LAST) ? '0 : rptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wptr_ff] <= push_entry;
      end
   end

   assign head      = slots_ff[rptr_ff];
   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == bsr_pkg::QCNT_FULL);

endmodule

### sv/bsr_front.sv
// Front end: accepts items, classifies them against the window and pushes
// them into the queue. Depends on bsr_pkg.
module bsr_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [31:0]         req_byte_position,
   input  logic                req_carries_byte,
   input  logic [7:0]          req_in_byte,
   input  logic                req_segment_end,
   input  logic                req_eof_segment,
   input  bsr_pkg::win_type    win,
   input  logic                seg_done,
   input  logic                q_full,
   output logic                push,
   output bsr_pkg::entry_type  push_entry
);

   logic                        seg_hold_ff, seg_hold_in;
   logic [32:0]                 offset;
   logic [bsr_pkg::SLOT_W:0]    slot_sum;
   logic [bsr_pkg::SLOT_W:0]    slot_fix;
   logic [32:0]                 end_pos;

   // Hold off new items while a segment end is in flight (the window moves) or the queue is full
   assign busy = seg_hold_ff || q_full;
   assign push = start && !busy;

   always_comb begin
      offset   = {1'b0, req_byte_position} - {1'b0, win.next_expected};
      slot_sum = {1'b0, win.base_slot} + {1'b0, offset[bsr_pkg::SLOT_W-1:0]};
      slot_fix = (slot_sum >= bsr_pkg::WIN_EXT) ? slot_sum - bsr_pkg::WIN_EXT : slot_sum;
      end_pos  = {1'b0, req_byte_position} + {32'd0, req_carries_byte};

      push_entry.store    = req_carries_byte && !offset[32]
                            && (offset[31:0] < bsr_pkg::WIN_32);
      push_entry.slot     = slot_fix[bsr_pkg::SLOT_W-1:0];
      push_entry.data     = req_in_byte;
      push_entry.seg_end  = req_segment_end;
      push_entry.eof_take = req_segment_end && req_eof_segment
                            && (end_pos >= {1'b0, win.next_expected});
      push_entry.eof_pos  = end_pos;

      seg_hold_in = seg_hold_ff;
      if (push && req_segment_end) begin
         seg_hold_in = 1'b1;
      end else if (seg_done) begin
         seg_hold_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_hold_ff <= 1'b0;
      end else begin
         seg_hold_ff <= seg_hold_in;
      end
   end

endmodule

### sv/bsr_back.sv
// Back end: stores bytes, keeps valid marks and counts, drains the in-order
// run through the window RAM and forms the results. Depends on bsr_pkg.
module bsr_back (
   input  logic                          clock,
   input  logic                          reset,
   input  bsr_pkg::entry_type            head,
   input  logic                          not_empty,
   output logic                          pop,
   output bsr_pkg::win_type              win,
   output logic                          seg_done,
   output logic                          ram_wr_en,
   output logic [bsr_pkg::SLOT_W-1:0]    ram_wr_addr,
   output logic [7:0]                    ram_wr_data,
   output logic                          ram_rd_en,
   output logic [bsr_pkg::SLOT_W-1:0]    ram_rd_addr,
   input  logic [7:0]                    ram_rd_data,
   output bsr_pkg::rsp_type              rsp
);

   bsr_pkg::back_state_type             state_ff, state_in;
   logic [31:0]                         ne_ff, ne_in;
   logic [bsr_pkg::SLOT_W-1:0]          ne_slot_ff, ne_slot_in;
   logic [bsr_pkg::SLOT_W-1:0]          next_slot;
   logic [bsr_pkg::CNT_W-1:0]           pend_ff, pend_in;
   logic [32:0]                         eof_pos_ff, eof_pos_in;
   logic                                eof_known_ff, eof_known_in;
   logic                                ended_ff, ended_in;
   logic [bsr_pkg::WINDOW_BYTES-1:0]    valid_ff, valid_in;
   logic                                stat_vld_ff, stat_vld_in;
   logic [bsr_pkg::CNT_W-1:0]           stat_pend_ff, stat_pend_in;
   logic                                stat_ended_ff, stat_ended_in;
   logic                                tag_vld_ff, tag_vld_in;
   logic                                tag_last_ff, tag_last_in;
   logic [bsr_pkg::CNT_W-1:0]           tag_pend_ff, tag_pend_in;
   logic                                tag_ended_ff, tag_ended_in;
   logic [31:0]                         ne_plus;

   assign next_slot = (ne_slot_ff == bsr_pkg::SLOT_LAST) ? '0 : ne_slot_ff + bsr_pkg::SLOT_ONE;
   assign ne_plus   = ne_ff + 32'd1;

   always_comb begin
      state_in      = state_ff;
      ne_in         = ne_ff;
      ne_slot_in    = ne_slot_ff;
      pend_in       = pend_ff;
      eof_pos_in    = eof_pos_ff;
      eof_known_in  = eof_known_ff;
      ended_in      = ended_ff;
      valid_in      = valid_ff;
      stat_vld_in   = 1'b0;
      stat_pend_in  = stat_pend_ff;
      stat_ended_in = stat_ended_ff;
      tag_vld_in    = 1'b0;
      tag_last_in   = tag_last_ff;
      tag_pend_in   = tag_pend_ff;
      tag_ended_in  = tag_ended_ff;
      pop           = 1'b0;
      seg_done      = 1'b0;
      ram_wr_en     = 1'b0;
      ram_rd_en     = 1'b0;

      unique case (state_ff)
         bsr_pkg::ST_IDLE: begin
            if (not_empty) begin
               pop = 1'b1;
               if (head.store) begin
                  ram_wr_en = 1'b1;
                  valid_in[head.slot] = 1'b1;
                  if (!valid_ff[head.slot] && pend_ff < bsr_pkg::PEND_MAX) begin
                     pend_in = pend_ff + 1'b1;
                  end
               end
               if (head.seg_end) begin
                  if (head.eof_take) begin
                     eof_pos_in   = head.eof_pos;
                     eof_known_in = 1'b1;
                  end
                  state_in = bsr_pkg::ST_DRAIN;
               end else begin
                  stat_vld_in   = 1'b1;
                  stat_pend_in  = pend_in;
                  stat_ended_in = ended_ff;
               end
            end
         end
         bsr_pkg::ST_DRAIN: begin
            if (valid_ff[ne_slot_ff]) begin
               // Release one byte; its data shows up from the RAM next cycle
               ram_rd_en = 1'b1;
               valid_in[ne_slot_ff] = 1'b0;
               if (pend_ff != '0) begin
                  pend_in = pend_ff - 1'b1;
               end
               ne_in      = ne_plus;
               ne_slot_in = next_slot;
               if (eof_known_ff && ({1'b0, ne_plus} == eof_pos_ff) && (pend_in == '0)) begin
                  ended_in = 1'b1;
               end
               tag_vld_in   = 1'b1;
               tag_pend_in  = pend_in;
               tag_ended_in = ended_in;
               tag_last_in  = !valid_ff[next_slot];
               if (!valid_ff[next_slot]) begin
                  seg_done = 1'b1;
                  state_in = bsr_pkg::ST_IDLE;
               end
            end else begin
               // Nothing to release: one status result after the end check
               if (eof_known_ff && ({1'b0, ne_ff} == eof_pos_ff) && (pend_ff == '0)) begin
                  ended_in = 1'b1;
               end
               stat_vld_in   = 1'b1;
               stat_pend_in  = pend_ff;
               stat_ended_in = ended_in;
               seg_done      = 1'b1;
               state_in      = bsr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bsr_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bsr_pkg::ST_IDLE;
         ne_ff        <= '0;
         ne_slot_ff   <= '0;
         pend_ff      <= '0;
         eof_pos_ff   <= '0;
         eof_known_ff <= 1'b0;
         ended_ff     <= 1'b0;
         valid_ff     <= '0;
         stat_vld_ff  <= 1'b0;
         tag_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ne_ff        <= ne_in;
         ne_slot_ff   <= ne_slot_in;
         pend_ff      <= pend_in;
         eof_pos_ff   <= eof_pos_in;
         eof_known_ff <= eof_known_in;
         ended_ff     <= ended_in;
         valid_ff     <= valid_in;
         stat_vld_ff  <= stat_vld_in;
         tag_vld_ff   <= tag_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      stat_pend_ff  <= stat_pend_in;
      stat_ended_ff <= stat_ended_in;
      tag_last_ff   <= tag_last_in;
      tag_pend_ff   <= tag_pend_in;
      tag_ended_ff  <= tag_ended_in;
   end

   assign win.next_expected = ne_ff;
   assign win.base_slot     = ne_slot_ff;
   assign ram_wr_addr       = head.slot;
   assign ram_wr_data       = head.data;
   assign ram_rd_addr       = ne_slot_ff;

   always_comb begin
      rsp.strobe        = stat_vld_ff || tag_vld_ff;
      rsp.has_byte      = tag_vld_ff;
      rsp.out_byte      = tag_vld_ff ? ram_rd_data : 8'd0;
      rsp.pending_count = tag_vld_ff ? tag_pend_ff : stat_pend_ff;
      rsp.stream_ended  = tag_vld_ff ? tag_ended_ff : stat_ended_ff;
      rsp.last          = tag_vld_ff ? tag_last_ff : 1'b1;
   end

endmodule

### sv/byte_stream_reassembler.sv
// Top level of the byte stream reassembler: front end, queue, back end and
// window RAM. Depends on bsr_pkg, bsr_front, bsr_queue, bsr_back, bsr_ram.
//
// Bytes arrive one per transfer with their absolute stream position; bytes
// inside the window starting at the next expected position are stored, all
// others are dropped. A transfer is taken when start is high and busy low.
// Each transfer gives one or more results, each shown for exactly one cycle
// under rsp_strobe; the receiver cannot stall, so results must be captured
// when they appear, and rsp_last marks the final one of a transfer. An item
// without a segment end gives one status result, registered through the queue
// and the back end's status flops, and such items can be sent every cycle
// (the two-entry queue and the one-item-per-cycle back end keep up). A
// segment end holds busy until the in-order run is drained by the walk over
// valid marks, one slot per cycle through the single read port of the window
// RAM. The window RAM needs no clearing; valid marks are flip-flops cleared
// by reset.
module byte_stream_reassembler (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [31:0]                req_byte_position,
   input  logic                       req_carries_byte,
   input  logic [7:0]                 req_in_byte,
   input  logic                       req_segment_end,
   input  logic                       req_eof_segment,
   output logic                       rsp_strobe,
   output logic                       rsp_has_byte,
   output logic [7:0]                 rsp_out_byte,
   output logic [bsr_pkg::CNT_W-1:0]  rsp_pending_count,
   output logic                       rsp_stream_ended,
   output logic                       rsp_last
);

   bsr_pkg::entry_type              push_entry;
   bsr_pkg::entry_type              head;
   bsr_pkg::win_type                win;
   bsr_pkg::rsp_type                rsp;
   logic                            push;
   logic                            pop;
   logic                            not_empty;
   logic                            q_full;
   logic                            seg_done;
   logic                            ram_wr_en;
   logic [bsr_pkg::SLOT_W-1:0]      ram_wr_addr;
   logic [7:0]                      ram_wr_data;
   logic                            ram_rd_en;
   logic [bsr_pkg::SLOT_W-1:0]      ram_rd_addr;
   logic [7:0]                      ram_rd_data;

   // Classify each transfer against the current window and queue it
   bsr_front u_front (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_byte_position (req_byte_position),
      .req_carries_byte  (req_carries_byte),
      .req_in_byte       (req_in_byte),
      .req_segment_end   (req_segment_end),
      .req_eof_segment   (req_eof_segment),
      .win               (win),
      .seg_done          (seg_done),
      .q_full            (q_full),
      .push              (push),
      .push_entry        (push_entry)
   );

   bsr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .not_empty  (not_empty),
      .full       (q_full)
   );

   // Store, drain and report
   bsr_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .not_empty   (not_empty),
      .pop         (pop),
      .win         (win),
      .seg_done    (seg_done),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .rsp         (rsp)
   );

   // Window byte store, slot = position mod window size
   bsr_ram #(
      .WIDTH (8),
      .DEPTH (bsr_pkg::WINDOW_BYTES)
   ) u_window_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_strobe        = rsp.strobe;
   assign rsp_has_byte      = rsp.has_byte;
   assign rsp_out_byte      = rsp.out_byte;
   assign rsp_pending_count = rsp.pending_count;
   assign rsp_stream_ended  = rsp.stream_ended;
   assign rsp_last          = rsp.last;

endmodule
